[design/b64d_pkg.sv]
package b64d_pkg;

   // Depth of the group queue between the decode front and the byte serializer
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UZ    = 8'h5A;  // 'Z'
   localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LZ    = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_D0    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_D9    = 8'h39;  // '9'

   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;
   localparam logic [5:0] LOWER_BASE   = 6'd26;
   localparam logic [5:0] DIGIT_BASE   = 6'd52;

   // One decoded group: up to three bytes, count is 1..3
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] n;
   } job_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] v;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      logic [7:0] d;
      r.ok = 1'b1;
      r.v  = '0;
      d    = '0;
      if (c >= CHAR_UA && c <= CHAR_UZ) begin
         d   = c - CHAR_UA;
         r.v = d[5:0];
      end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
         d   = c - CHAR_LA;
         r.v = d[5:0] + LOWER_BASE;
      end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
         d   = c - CHAR_D0;
         r.v = d[5:0] + DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         r.v = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         r.v = SEXTET_SLASH;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

[design/b64d_front.sv]
module b64d_front
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_string,
   input  logic       queue_full,
   output logic       push,
   output job_type    job
);

   logic [2:0][5:0] buf_ff, buf_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            fin_ff, fin_in;

   sextet_type sx;
   logic       accept;
   logic       full_grp;
   logic       pad;
   logic [5:0] s3;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign sx        = sextet_of(req_char_code);
   assign full_grp  = !fin_ff && sx.ok && (cnt_ff == 2'd3);
   assign pad       = !fin_ff && !sx.ok && (req_char_code == CHAR_PAD);
   assign s3        = full_grp ? sx.v : 6'd0;

   // Unfilled slots are always zero, so a padded group reads them as zero
   always_comb begin
      job.b0 = {buf_ff[0], buf_ff[1][5:4]};
      job.b1 = {buf_ff[1][3:0], buf_ff[2][5:2]};
      job.b2 = {buf_ff[2][1:0], s3};
      if (full_grp) begin
         job.n = 2'd3;
      end else if (pad && cnt_ff > 2'd1) begin
         job.n = cnt_ff - 2'd1;
      end else begin
         job.n = 2'd0;
      end
   end

   assign push = accept && (job.n != 2'd0);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      if (accept) begin
         if (req_end_of_string || full_grp || pad) begin
            buf_in = '0;
            cnt_in = '0;
         end else if (!fin_ff && sx.ok) begin
            for (int i = 0; i < 3; i++) begin
               if (cnt_ff == i[1:0]) begin
                  buf_in[i] = sx.v;
               end
            end
            cnt_in = cnt_ff + 2'd1;
         end
         if (req_end_of_string) begin
            fin_in = 1'b0;
         end else if (pad) begin
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         cnt_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
      end
   end

   a_fin_empty: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> (cnt_ff == 2'd0 && buf_ff == '0))
      else $error("group not empty after pad");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_string) |=> (cnt_ff == 2'd0 && !fin_ff && buf_ff == '0))
      else $error("end of string did not clear state");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("group pushed into full queue");

endmodule

[design/b64d_fifo.sv]
module b64d_fifo
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output job_type head
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   localparam logic [QCNT_W-1:0] DEPTH_C = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] LAST_C  = QPTR_W'(QUEUE_DEPTH - 1);

   assign full      = (cnt_ff == DEPTH_C);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_C) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_C) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      not_empty |-> (head.n != 2'd0))
      else $error("queued group with no bytes");

endmodule

[design/b64d_back.sv]
module b64d_back
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_of_run
);

   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign rsp_valid       = head_valid;
   assign rsp_last_of_run = (idx_ff == head.n - 2'd1);
   assign take            = rsp_valid && rsp_ready;
   assign pop             = take && rsp_last_of_run;

   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_data_byte = head.b0;
         2'd1:    rsp_data_byte = head.b1;
         default: rsp_data_byte = head.b2;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = rsp_last_of_run ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[design/base64_decoder_unit.sv]
// Base64 decoder (standard alphabet). One character enters per item on the
// req_ channel; alphabet characters are gathered four at a time and each full
// group gives three bytes on the rsp_ channel, one byte per item, with
// rsp_last_of_run marking the last byte of the group. Characters outside the
// alphabet are skipped. An '=' closes the string: a partial group of k sextets
// gives k-1 bytes and every later character is ignored until an item with
// req_end_of_string, which is also ignored and then clears all state.
// Without '=', that item is decoded normally first and a partial group left at the
// end is dropped. Rate: one character per cycle in while req_ready is high;
// one byte per cycle out while rsp_ready is high. A four-entry group queue
// sits between the decode front and the byte serializer; req_ready drops
// only while that queue is full. A group enters the queue with the character
// that completes it and reaches rsp_ once the groups ahead of it are out.
module base64_decoder_unit
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_of_run
);

   // decode front -> queue
   logic    push;
   job_type push_job;
   logic    queue_full;

   // queue -> byte serializer
   logic    not_empty;
   logic    pop;
   job_type head;

   b64d_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push              (push),
      .job               (push_job)
   );

   b64d_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .not_empty (not_empty),
      .pop       (pop),
      .head      (head)
   );

   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (not_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[dv/tb_base64_decoder_unit.sv]
module tb_base64_decoder_unit;
   import b64d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Stimulus sizing
   localparam int unsigned ITEM_TARGET      = 210;
   // The sink holds off once for a long stretch after this many bytes, long
   // enough that the four-group queue fills and req_ready drops.
   localparam int unsigned LONG_HOLD_AT     = 70;
   localparam int unsigned LONG_HOLD_CYCLES = 150;
   // Cycles allowed after the last expected byte for stray output
   localparam int unsigned TAIL_CYCLES      = 16;

   // One character waiting to be offered on req_
   typedef struct {
      logic [7:0]  ch;
      logic        eos;
      int unsigned gap;        // idle cycles before offering it
      bit          wait_drain; // offer only once every expected byte is out
   } char_item_type;

   // One decoded byte as it should appear on rsp_
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_run;
   } byte_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = '0;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_last_of_run;

   char_item_type   char_queue[$];
   byte_result_type expected_bytes[$];

   // Decoder state mirrored by the predictor
   logic [5:0] held_sextet [3] = '{default: '0};
   logic [1:0] held_count = '0;
   logic       pad_seen = 1'b0;

   int unsigned mismatches = 0;
   int unsigned queued_chars = 0;
   // Both are written with nonblocking assignments so that other processes
   // read a settled value from the previous edge.
   int unsigned open_results = 0;
   logic        stim_done = 1'b0;

   base64_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Sextet value of an alphabet character, -1 for anything else
   function automatic int sextet_value(input logic [7:0] ch);
      if (ch >= CHAR_UA && ch <= CHAR_UZ) return int'(ch - CHAR_UA);
      if (ch >= CHAR_LA && ch <= CHAR_LZ) return int'(ch - CHAR_LA) + 26;
      if (ch >= CHAR_D0 && ch <= CHAR_D9) return int'(ch - CHAR_D0) + 52;
      if (ch == CHAR_PLUS) return 62;
      if (ch == CHAR_SLASH) return 63;
      return -1;
   endfunction

   // Applies one accepted character to the mirrored state and queues the
   // bytes it releases, MSB first, last one flagged.
   task automatic decode_char(input logic [7:0] ch, input logic eos);
      int          v;
      int unsigned n;
      logic [23:0] word;
      n    = 0;
      word = '0;
      if (!pad_seen) begin
         v = sextet_value(ch);
         if (v >= 0) begin
            if (held_count == 2'd3) begin
               word = {held_sextet[0], held_sextet[1], held_sextet[2], 6'(v)};
               n    = 3;
               held_sextet = '{default: '0};
               held_count  = '0;
            end else begin
               held_sextet[held_count] = 6'(v);
               held_count = held_count + 2'd1;
            end
         end else if (ch == CHAR_PAD) begin
            // unfilled slots are already zero, so they read as zero sextets
            word = {held_sextet[0], held_sextet[1], held_sextet[2], 6'd0};
            n    = (held_count > 2'd1) ? held_count - 1 : 0;
            held_sextet = '{default: '0};
            held_count  = '0;
            pad_seen    = 1'b1;
         end
      end
      for (int unsigned k = 0; k < n; k++)
         expected_bytes.push_back('{data_byte: word[23 - 8*k -: 8],
                                    last_of_run: (k == n - 1)});
      // end marker: its own character is handled first, then all clears
      if (eos) begin
         held_sextet = '{default: '0};
         held_count  = '0;
         pad_seen    = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [7:0] b64_symbol(input int unsigned v);
      if (v < 26) return 8'(CHAR_UA + v);
      if (v < 52) return 8'(CHAR_LA + v - 26);
      if (v < 62) return 8'(CHAR_D0 + v - 52);
      return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
   endfunction

   function automatic void push_char(input logic [7:0] ch, input logic eos,
                                     input int unsigned gap, input bit wait_drain);
      char_queue.push_back('{ch: ch, eos: eos, gap: gap, wait_drain: wait_drain});
      queued_chars++;
   endfunction

   // Queues a string with end_of_string on its last character. A burst
   // string is sent back to back.
   function automatic void queue_string(input logic [7:0] text[$], input bit burst,
                                        input bit wait_drain);
      foreach (text[i])
         push_char(text[i], i == text.size() - 1,
                   burst ? 0 : $urandom_range(0, 3), wait_drain && i == 0);
   endfunction

   function automatic void queue_text(input string s, input bit burst);
      logic [7:0] text[$];
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
      queue_string(text, burst, 1'b0);
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers queued characters, honors per-item gaps and drain waits
   // ------------------------------------------------------------------
   int unsigned gap_left  = 0;
   bit          gap_armed = 1'b0;

   always @(posedge clock) begin : char_driver
      char_item_type nxt;
      bit            offering;
      bit            just_took;
      if (reset) begin
         req_valid         <= 1'b0;
         req_char_code     <= '0;
         req_end_of_string <= 1'b0;
         stim_done         <= 1'b0;
         gap_left  = 0;
         gap_armed = 1'b0;
      end else begin
         just_took = req_valid && req_ready;
         offering  = req_valid && !just_took;
         if (!offering && char_queue.size() != 0) begin
            if (!gap_armed) begin
               gap_left  = char_queue[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left != 0) begin
               gap_left--;
            // open_results is registered and does not yet count the previous character's
            // bytes, so a drain wait never passes on the very edge that took that character
            end else if (!char_queue[0].wait_drain || (!just_took && open_results == 0)) begin
               nxt = char_queue.pop_front();
               gap_armed = 1'b0;
               req_char_code     <= nxt.ch;
               req_end_of_string <= nxt.eos;
               offering = 1'b1;
            end
         end
         req_valid <= offering;
         stim_done <= !offering && char_queue.size() == 0;
      end
   end

   // ------------------------------------------------------------------
   // Byte sink: short random stalls, a stall-free stretch, and one
   // long hold-off that backs the block up into its input
   // ------------------------------------------------------------------
   int unsigned hold_left   = 0;
   int unsigned sink_taken  = 0;

   always @(posedge clock) begin : byte_sink
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left  = 0;
         sink_taken = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sink_taken++;
            if (sink_taken == LONG_HOLD_AT)
               hold_left = LONG_HOLD_CYCLES;
            else if ((sink_taken / 40) % 3 == 1)
               hold_left = 0;
            else
               hold_left = $urandom_range(0, 3);
         end else if (hold_left != 0) begin
            hold_left--;
         end
         rsp_ready <= (hold_left == 0);
      end
   end

   // ------------------------------------------------------------------
   // Monitor and checker. Prediction runs before the compare so that the
   // order of the two handshakes within an edge never matters.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : byte_checker
      byte_result_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            decode_char(req_char_code, req_end_of_string);
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected byte: expected none, got data %02h last %0b",
                        $realtime, rsp_data_byte, rsp_last_of_run);
               mismatches++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data_byte !== want.data_byte) begin
                  $display("%0t: data_byte mismatch: expected %02h, got %02h",
                           $realtime, want.data_byte, rsp_data_byte);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                           $realtime, want.last_of_run, rsp_last_of_run);
                  mismatches++;
               end
            end
         end
         open_results <= expected_bytes.size();
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      logic [7:0]  text[$];
      int unsigned str_idx;
      int unsigned kind;
      int unsigned groups;
      int unsigned tail;
      bit          burst;

      // Directed strings
      queue_text("AZa0", 1'b0);              // one full group, alphabet edges
      // skipped codes 00 and FF interleaved; the end marker completes a group
      push_char(8'h00, 1'b0, 0, 1'b0);
      push_char(CHAR_SLASH, 1'b0, 1, 1'b0);
      push_char(8'hFF, 1'b0, 0, 1'b0);
      push_char(CHAR_PLUS, 1'b0, 2, 1'b0);
      push_char(CHAR_LZ, 1'b0, 0, 1'b0);
      push_char(CHAR_D9, 1'b1, 3, 1'b0);
      queue_text("QQ==A", 1'b1);             // two sextets padded, then ignored chars
      queue_text("=", 1'b0);                 // pad on an empty group
      queue_text("Q=", 1'b1);                // pad on a single sextet
      queue_text("QUI=", 1'b0);              // three sextets padded
      queue_text("QU", 1'b1);                // unpadded tail, dropped

      // Random strings: mostly well formed, some noise, some broken padding
      str_idx = 0;
      while (queued_chars < ITEM_TARGET) begin
         text.delete();
         burst = (str_idx % 6 == 3);
         kind  = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 8))
               text.push_back(8'($urandom_range(0, 255)));
         end else begin
            groups = $urandom_range(0, 4);
            tail   = $urandom_range(0, 3);
            repeat (4 * groups + tail) begin
               if ($urandom_range(0, 9) == 0)
                  text.push_back(8'($urandom_range(0, 255)));
               text.push_back(b64_symbol($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 4) != 0) begin
               text.push_back(CHAR_PAD);
               if (tail == 2 && $urandom_range(0, 1) == 1)
                  text.push_back(CHAR_PAD);
               // junk after the pad must be ignored
               if ($urandom_range(0, 3) == 0)
                  text.push_back($urandom_range(0, 1) ? CHAR_PAD
                                 : b64_symbol($urandom_range(0, 63)));
            end
            // sometimes the end marker rides on a stray character
            if ($urandom_range(0, 4) == 0)
               text.push_back(8'($urandom_range(0, 255)));
            if (text.size() == 0)
               text.push_back(b64_symbol($urandom_range(0, 63)));
         end
         // the first random string waits for the directed part to drain; the one at index 20 waits too
         queue_string(text, burst, str_idx == 0 || str_idx == 20);
         str_idx++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (!(stim_done && open_results == 0));
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (open_results != 0)
         mismatches++;
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
